FILE: design/tla_pkg.sv
// constants and lookup table for the thermistor linearizer and averager
`timescale 1ns / 1ps

package tla_pkg;

  localparam int CHAN_W        = 5;
  localparam int RAW_W         = 16;
  localparam int TEMP_W        = 17;
  localparam int X_W           = 12;
  localparam int SLOPE_W       = 10;
  localparam int TABLE_ENTRIES = 120;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int AVG_DEPTH_DEF = 10;

  localparam logic [RAW_W-1:0] RAW_MASK = 16'hFFF0;

  // y of entry i is Y_BASE + Y_STEP * i
  localparam int Y_BASE = 10000;
  localparam int Y_STEP = 1000;
  localparam int Y_MAX  = Y_BASE + Y_STEP * (TABLE_ENTRIES - 1);

  // configuration register indexes
  localparam logic CFG_HEATER = 1'b0;
  localparam logic CFG_INLET  = 1'b1;

  localparam logic [CHAN_W-1:0] HEATER_CH_RST = 5'd2;
  localparam logic [CHAN_W-1:0] INLET_CH_RST  = 5'd5;

  // descending raw value breakpoints
  localparam logic [X_W-1:0] LUT_X [TABLE_ENTRIES] = '{
    12'd3624, 12'd3603, 12'd3581, 12'd3558, 12'd3534, 12'd3509, 12'd3484, 12'd3458,
    12'd3432, 12'd3404, 12'd3376, 12'd3347, 12'd3318, 12'd3287, 12'd3256, 12'd3225,
    12'd3192, 12'd3159, 12'd3126, 12'd3091, 12'd3056, 12'd3021, 12'd2985, 12'd2948,
    12'd2911, 12'd2873, 12'd2835, 12'd2797, 12'd2758, 12'd2718, 12'd2679, 12'd2639,
    12'd2598, 12'd2558, 12'd2517, 12'd2476, 12'd2435, 12'd2394, 12'd2353, 12'd2312,
    12'd2271, 12'd2229, 12'd2186, 12'd2147, 12'd2106, 12'd2066, 12'd2025, 12'd1985,
    12'd1945, 12'd1905, 12'd1866, 12'd1826, 12'd1788, 12'd1749, 12'd1711, 12'd1674,
    12'd1637, 12'd1600, 12'd1564, 12'd1529, 12'd1493, 12'd1459, 12'd1425, 12'd1391,
    12'd1358, 12'd1326, 12'd1294, 12'd1263, 12'd1232, 12'd1202, 12'd1173, 12'd1144,
    12'd1115, 12'd1088, 12'd1060, 12'd1034, 12'd1008, 12'd982,  12'd957,  12'd933,
    12'd909,  12'd886,  12'd863,  12'd841,  12'd819,  12'd798,  12'd778,  12'd758,
    12'd738,  12'd719,  12'd700,  12'd682,  12'd664,  12'd647,  12'd630,  12'd614,
    12'd598,  12'd583,  12'd569,  12'd553,  12'd538,  12'd524,  12'd511,  12'd498,
    12'd485,  12'd472,  12'd460,  12'd448,  12'd437,  12'd426,  12'd415,  12'd404,
    12'd394,  12'd384,  12'd374,  12'd364,  12'd355,  12'd346,  12'd337,  12'd329
  };

endpackage

FILE: design/thermistor_linearize_average.sv
// thermistor linearizer with per-sensor moving average over a ring memory
`timescale 1ns / 1ps

// Takes one ADC scan beat on the in_ stream and returns exactly one result beat on
// the out_ stream. Words flagged invalid, or on a channel other than the heater or
// inlet channel, go straight to the response state and give a result with updated low.
// A matched word walks the breakpoint table one entry a cycle, divides the segment
// rise by its run in a shift-subtract divider (one bit a cycle), multiplies, checks
// range and writes the sample into the sensor's ring in a single-port-write memory
// (a word out of range sets the sensor's fault bit instead). Once the ring has
// filled, the mean is formed by reading it back one entry a cycle and one multiply
// by the reciprocal of AVG_DEPTH.
// One item is in work at a time; in_tready is high only while the block is idle.
// The result sits in an output register, so the next beat is taken while it waits;
// a stalled receiver holds the block only when the next result is ready to go.
// Reset (rst_n low at a clock edge) clears fill state, averages, faults and the
// channel registers to 2 and 5; ring contents need no clearing.
// cfg_ writes are taken at any edge with cfg_wr_en high, meant for idle times.
module thermistor_linearize_average #(
  parameter int AVG_DEPTH = tla_pkg::AVG_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [23:0]               in_tdata,   // adc_channel[4:0], raw_sample[20:5]
  input  logic                      in_tuser,   // word_invalid
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [23:0]               out_tdata,  // average_temp[16:0], average_ready[17],
                                                // sensor_errors[19:18]
  output logic [1:0]                out_tuser,  // updated[0], sensor_index[1]
  input  logic                      cfg_wr_en,
  input  logic                      cfg_index,
  input  logic [tla_pkg::CHAN_W-1:0] cfg_wdata
);

  localparam int POS_W   = $clog2(AVG_DEPTH);
  localparam int K_W     = $clog2(AVG_DEPTH + 1);
  localparam int ADDR_W  = $clog2(2 * AVG_DEPTH);
  localparam int SUM_W   = tla_pkg::TEMP_W + $clog2(AVG_DEPTH);
  localparam int DVD_W   = tla_pkg::SLOPE_W;
  localparam int DVS_W   = tla_pkg::X_W;
  localparam int CNT_W   = $clog2(DVD_W);
  localparam int PROD_W  = tla_pkg::X_W + tla_pkg::SLOPE_W;
  localparam int VAL_W   = PROD_W + 1;
  localparam int IDX_W   = tla_pkg::IDX_W;
  localparam int TEMP_W  = tla_pkg::TEMP_W;
  localparam int X_W     = tla_pkg::X_W;
  localparam int MEM_D   = 2 * AVG_DEPTH;
  localparam int RCP_SH  = SUM_W + $clog2(AVG_DEPTH);
  localparam int RCP_W   = SUM_W + 1;
  localparam int MPY_W   = SUM_W + RCP_W;
  // rounded-up reciprocal, exact floor division for every sum that fits SUM_W
  localparam logic [RCP_W-1:0] RCP_M =
    RCP_W'(((64'd1 << RCP_SH) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_SEARCH = 9'b000000010,
    ST_SDIV   = 9'b000000100,
    ST_MUL    = 9'b000001000,
    ST_CHECK  = 9'b000010000,
    ST_WRITE  = 9'b000100000,
    ST_SUM    = 9'b001000000,
    ST_ADIV   = 9'b010000000,
    ST_RESP   = 9'b100000000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [tla_pkg::CHAN_W-1:0]  heater_ch_r, heater_ch_nxt;
  logic [tla_pkg::CHAN_W-1:0]  inlet_ch_r, inlet_ch_nxt;
  logic [tla_pkg::RAW_W-1:0]   raw_r, raw_nxt;
  logic                        sens_r, sens_nxt;
  logic                        upd_r, upd_nxt;
  logic [IDX_W-1:0]            idx_r, idx_nxt;
  logic [X_W-1:0]              prev_x_r, prev_x_nxt;
  logic [X_W-1:0]              diff_r, diff_nxt;
  logic [TEMP_W-1:0]           base_y_r, base_y_nxt;
  logic [tla_pkg::SLOPE_W-1:0] slope_r, slope_nxt;
  logic [PROD_W-1:0]           prod_r, prod_nxt;
  logic [TEMP_W-1:0]           temp_r, temp_nxt;
  logic [POS_W-1:0]            pos_r [2];
  logic [POS_W-1:0]            pos_nxt [2];
  logic [1:0]                  full_r, full_nxt;
  logic [TEMP_W-1:0]           avg_r [2];
  logic [TEMP_W-1:0]           avg_nxt [2];
  logic [1:0]                  fault_r, fault_nxt;
  logic [K_W-1:0]              k_r, k_nxt;
  logic                        rd_vld_r, rd_vld_nxt;
  logic [SUM_W-1:0]            sum_r, sum_nxt;
  logic [DVD_W-1:0]            div_quo_r, div_quo_nxt;
  logic [DVS_W-1:0]            div_rem_r, div_rem_nxt;
  logic [DVS_W-1:0]            div_d_r, div_d_nxt;
  logic [CNT_W-1:0]            div_cnt_r, div_cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [23:0]                 out_data_r, out_data_nxt;
  logic [1:0]                  out_user_r, out_user_nxt;

  logic [TEMP_W-1:0]           ring_mem [MEM_D];
  logic [TEMP_W-1:0]           mem_q;
  logic                        mem_we;
  logic [ADDR_W-1:0]           mem_waddr, mem_raddr, ring_base;

  logic [tla_pkg::CHAN_W-1:0]  in_chan;
  logic [tla_pkg::RAW_W-1:0]   in_raw;
  logic                        hit_h, hit_i;
  logic [X_W-1:0]              cur_x;
  logic [IDX_W-1:0]            idx_m1;
  logic [DVS_W:0]              div_sh;
  logic [DVS_W+1:0]            div_tr;
  logic                        div_ge;
  logic [DVS_W-1:0]            div_rem_step;
  logic [DVD_W-1:0]            div_quo_step;
  logic                        div_last;
  logic [VAL_W-1:0]            val;
  logic [POS_W-1:0]            pos_cur;
  logic [MPY_W-1:0]            avg_mpy;

  assign in_chan = in_tdata[4:0];
  assign in_raw  = in_tdata[20:5];
  assign hit_h   = !in_tuser && (in_chan == heater_ch_r);
  assign hit_i   = !in_tuser && !hit_h && (in_chan == inlet_ch_r);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign cur_x  = tla_pkg::LUT_X[idx_r];
  assign idx_m1 = idx_r - IDX_W'(1);

  // shift-subtract divider step
  assign div_sh       = {div_rem_r, div_quo_r[DVD_W-1]};
  assign div_tr       = {1'b0, div_sh} - {2'b00, div_d_r};
  assign div_ge       = !div_tr[DVS_W+1];
  assign div_rem_step = div_ge ? div_tr[DVS_W-1:0] : div_sh[DVS_W-1:0];
  assign div_quo_step = {div_quo_r[DVD_W-2:0], div_ge};
  assign div_last     = (div_cnt_r == CNT_W'(DVD_W - 1));

  // ring sum times the reciprocal of the depth
  assign avg_mpy = MPY_W'(sum_r) * MPY_W'(RCP_M);

  assign val     = VAL_W'(base_y_r) + VAL_W'(prod_r);
  assign pos_cur = pos_r[sens_r];

  assign ring_base = sens_r ? ADDR_W'(AVG_DEPTH) : '0;
  assign mem_waddr = ring_base + ADDR_W'(pos_cur);
  assign mem_raddr = ring_base + ADDR_W'(k_r);
  assign mem_we    = (state_r == ST_WRITE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= temp_r;
    end
    mem_q <= ring_mem[mem_raddr];
  end

  always_comb begin
    state_nxt     = state_r;
    heater_ch_nxt = heater_ch_r;
    inlet_ch_nxt  = inlet_ch_r;
    raw_nxt       = raw_r;
    sens_nxt      = sens_r;
    upd_nxt       = upd_r;
    idx_nxt       = idx_r;
    prev_x_nxt    = prev_x_r;
    diff_nxt      = diff_r;
    base_y_nxt    = base_y_r;
    slope_nxt     = slope_r;
    prod_nxt      = prod_r;
    temp_nxt      = temp_r;
    pos_nxt       = pos_r;
    full_nxt      = full_r;
    avg_nxt       = avg_r;
    fault_nxt     = fault_r;
    k_nxt         = k_r;
    rd_vld_nxt    = 1'b0;
    sum_nxt       = sum_r;
    div_quo_nxt   = div_quo_r;
    div_rem_nxt   = div_rem_r;
    div_d_nxt     = div_d_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_wr_en) begin
      unique case (cfg_index)
        tla_pkg::CFG_HEATER: heater_ch_nxt = cfg_wdata;
        tla_pkg::CFG_INLET:  inlet_ch_nxt  = cfg_wdata;
        default:             heater_ch_nxt = heater_ch_r;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          raw_nxt    = in_raw & tla_pkg::RAW_MASK;
          sens_nxt   = !hit_h;
          upd_nxt    = hit_h || hit_i;
          idx_nxt    = '0;
          prev_x_nxt = '0;
          state_nxt  = (hit_h || hit_i) ? ST_SEARCH : ST_RESP;
        end
      end
      ST_SEARCH: begin
        if (raw_r > {4'b0000, cur_x}) begin
          if (idx_r == '0) begin
            // above the first breakpoint: no segment to interpolate
            fault_nxt[sens_r] = 1'b1;
            state_nxt         = ST_RESP;
          end else begin
            div_d_nxt   = prev_x_r - cur_x;
            diff_nxt    = prev_x_r - raw_r[X_W-1:0];
            base_y_nxt  = TEMP_W'(tla_pkg::Y_BASE) + TEMP_W'(idx_m1) * TEMP_W'(tla_pkg::Y_STEP);
            div_quo_nxt = DVD_W'(tla_pkg::Y_STEP);
            div_rem_nxt = '0;
            div_cnt_nxt = '0;
            state_nxt   = ST_SDIV;
          end
        end else if (idx_r == IDX_W'(tla_pkg::TABLE_ENTRIES - 1)) begin
          // at or below the last breakpoint
          temp_nxt  = TEMP_W'(tla_pkg::Y_BASE);
          state_nxt = ST_WRITE;
        end else begin
          prev_x_nxt = cur_x;
          idx_nxt    = idx_r + IDX_W'(1);
        end
      end
      ST_SDIV: begin
        div_quo_nxt = div_quo_step;
        div_rem_nxt = div_rem_step;
        div_cnt_nxt = div_cnt_r + CNT_W'(1);
        if (div_last) begin
          slope_nxt = (div_d_r == '0) ? '0 : div_quo_step[tla_pkg::SLOPE_W-1:0];
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = PROD_W'(diff_r) * PROD_W'(slope_r);
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (val >= VAL_W'(tla_pkg::Y_BASE) && val <= VAL_W'(tla_pkg::Y_MAX)) begin
          temp_nxt  = val[TEMP_W-1:0];
          state_nxt = ST_WRITE;
        end else begin
          fault_nxt[sens_r] = 1'b1;
          state_nxt         = ST_RESP;
        end
      end
      ST_WRITE: begin
        k_nxt   = '0;
        sum_nxt = '0;
        if (pos_cur == POS_W'(AVG_DEPTH - 1)) begin
          pos_nxt[sens_r]  = '0;
          full_nxt[sens_r] = 1'b1;
          state_nxt        = ST_SUM;
        end else begin
          pos_nxt[sens_r] = pos_cur + POS_W'(1);
          state_nxt       = full_r[sens_r] ? ST_SUM : ST_RESP;
        end
      end
      ST_SUM: begin
        // read issued one cycle, data added the next
        if (rd_vld_r) begin
          sum_nxt = sum_r + SUM_W'(mem_q);
        end
        if (k_r != K_W'(AVG_DEPTH)) begin
          rd_vld_nxt = 1'b1;
          k_nxt      = k_r + K_W'(1);
        end else begin
          state_nxt  = ST_ADIV;
        end
      end
      ST_ADIV: begin
        avg_nxt[sens_r] = avg_mpy[RCP_SH +: TEMP_W];
        state_nxt       = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = {upd_r & sens_r, upd_r};
          out_data_nxt  = {4'b0000, fault_r,
                           upd_r & full_r[sens_r],
                           upd_r ? avg_r[sens_r] : {TEMP_W{1'b0}}};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      heater_ch_r <= tla_pkg::HEATER_CH_RST;
      inlet_ch_r  <= tla_pkg::INLET_CH_RST;
      pos_r[0]    <= '0;
      pos_r[1]    <= '0;
      full_r      <= '0;
      avg_r[0]    <= '0;
      avg_r[1]    <= '0;
      fault_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      heater_ch_r <= heater_ch_nxt;
      inlet_ch_r  <= inlet_ch_nxt;
      pos_r       <= pos_nxt;
      full_r      <= full_nxt;
      avg_r       <= avg_nxt;
      fault_r     <= fault_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    raw_r      <= raw_nxt;
    sens_r     <= sens_nxt;
    upd_r      <= upd_nxt;
    idx_r      <= idx_nxt;
    prev_x_r   <= prev_x_nxt;
    diff_r     <= diff_nxt;
    base_y_r   <= base_y_nxt;
    slope_r    <= slope_nxt;
    prod_r     <= prod_nxt;
    temp_r     <= temp_nxt;
    k_r        <= k_nxt;
    sum_r      <= sum_nxt;
    div_quo_r  <= div_quo_nxt;
    div_rem_r  <= div_rem_nxt;
    div_d_r    <= div_d_nxt;
    div_cnt_r  <= div_cnt_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  // a ready average is only reported on an updated result
  a_ready_needs_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[17] || out_tuser[0]))
    else $error("average_ready without updated");

  // fault bits are sticky
  a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((fault_r & $past(fault_r)) == $past(fault_r)))
    else $error("sensor fault bit cleared");

  // a new result is only loaded from the response state
  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(out_valid_r) |-> $past(state_r == ST_RESP))
    else $error("result loaded outside response state");

  // the mean pass only runs on a filled ring
  a_sum_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM) |-> full_r[sens_r])
    else $error("ring read before it filled");

endmodule
